// ===== rtl/core/pbr_pkg.sv =====
// ----------------------------------------------------------------------------
// pbr_pkg
// Shared types and constants of the block receiver: request and result
// payloads, the classified operation passed from front to back, and the
// characters used for lost-sync and cancel detection.
// ----------------------------------------------------------------------------
package pbr_pkg;

  // Input kind codes
  localparam logic [1:0] KIND_BEGIN   = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // Block length bounds and header geometry
  localparam logic [7:0] MIN_BLOCK_LEN = 8'd7;
  localparam int unsigned HDR_DEPTH    = 8;
  localparam int unsigned HDR_IDX_W    = $clog2(HDR_DEPTH);
  localparam logic [7:0] SUM_START     = 8'd4;
  localparam logic [7:0] ACK_COUNT     = 8'd3;
  localparam logic [7:0] SYNC_COUNT    = 8'd7;
  localparam logic [7:0] PAYLOAD_START = 8'd7;
  localparam logic [7:0] SHORT_LEN     = 8'd8;
  localparam logic [7:0] FINAL_HI_BYTE = 8'hff;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Characters
  localparam logic [7:0] CHR_A     = 8'h41;
  localparam logic [7:0] CHR_B     = 8'h42;
  localparam logic [7:0] CHR_C     = 8'h43;
  localparam logic [7:0] CHR_K     = 8'h4b;
  localparam logic [7:0] CHR_S     = 8'h53;
  localparam logic [7:0] CHR_SLASH = 8'h2f;

  // Lost-sync windows, header bytes 7 down to 2
  localparam logic [47:0] SYNC_ACKACK = {CHR_K, CHR_C, CHR_A, CHR_K, CHR_C, CHR_A};
  localparam logic [47:0] SYNC_CKACKA = {CHR_A, CHR_K, CHR_C, CHR_A, CHR_K, CHR_C};
  localparam logic [47:0] SYNC_KACKAC = {CHR_C, CHR_A, CHR_K, CHR_C, CHR_A, CHR_K};

  typedef enum logic [2:0] {
    ST_BUSY          = 3'd0,
    ST_PAYLOAD       = 3'd1,
    ST_GOOD          = 3'd2,
    ST_BAD_SUM       = 3'd3,
    ST_RESYNC        = 3'd4,
    ST_LATE_ACK      = 3'd5,
    ST_REMOTE_CANCEL = 3'd6,
    ST_TIMEOUT       = 3'd7
  } pbr_status_e;

  typedef enum logic [1:0] {
    OP_BEGIN   = 2'd0,
    OP_BYTE    = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_IGNORE  = 2'd3
  } pbr_op_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] block_length;
    logic [7:0] rx_byte;
  } pbr_in_t;

  typedef struct packed {
    pbr_status_e status;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [7:0]  next_size;
    logic [15:0] block_number;
    logic [7:0]  file_type;
    logic        final_block;
  } pbr_out_t;

  // Classified request held in the queue
  typedef struct packed {
    pbr_op_e    op;
    logic [7:0] length;
    logic [7:0] data;
  } pbr_req_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic     valid;
    pbr_req_t req;
  } pbr_head_t;

endpackage

// ===== rtl/core/pbr_front.sv =====
// ----------------------------------------------------------------------------
// pbr_front
// Classifies an incoming request by kind and clamps the block length of a
// begin request to the supported range.
// ----------------------------------------------------------------------------
module pbr_front import pbr_pkg::*; #(
  parameter int MAX_BLOCK_LEN = 255
) (
  input  pbr_in_t  in_data_i,
  output pbr_req_t req_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_BLOCK_LEN);

  // Decode the kind into an operation
  always_comb begin
    case (in_data_i.kind)
      KIND_BEGIN:   req_o.op = OP_BEGIN;
      KIND_BYTE:    req_o.op = OP_BYTE;
      KIND_TIMEOUT: req_o.op = OP_TIMEOUT;
      default:      req_o.op = OP_IGNORE;
    endcase
  end

  // Clamp the length into the supported range
  always_comb begin
    if (in_data_i.block_length < MIN_BLOCK_LEN) begin
      req_o.length = MIN_BLOCK_LEN;
    end else if (in_data_i.block_length > MaxLen) begin
      req_o.length = MaxLen;
    end else begin
      req_o.length = in_data_i.block_length;
    end
  end

  assign req_o.data = in_data_i.rx_byte;

endmodule

// ===== rtl/core/pbr_queue.sv =====
// ----------------------------------------------------------------------------
// pbr_queue
// Two-entry queue decoupling the front classifier from the back end.
// ----------------------------------------------------------------------------
module pbr_queue import pbr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pbr_req_t  req_i,
  output logic      full_o,
  output pbr_head_t head_o,
  input  logic      pop_i
);

  pbr_req_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0]   count_q, count_d;

  assign full_o     = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.req = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

// ===== rtl/core/pbr_back.sv =====
// ----------------------------------------------------------------------------
// pbr_back
// Executes classified requests against the block state: header capture,
// checksum and rotate-XOR code, lost-sync detection and the verdict, and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module pbr_back import pbr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pbr_head_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pbr_out_t  out_data_o
);

  logic [7:0]  hdr_q [HDR_DEPTH];
  logic [7:0]  hdr_d [HDR_DEPTH];
  logic [7:0]  hdr_w [HDR_DEPTH];
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  exp_q, exp_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] code_q, code_d;
  logic        out_valid_q, out_valid_d;
  pbr_out_t    out_q;
  pbr_out_t    rsp;

  logic        active;
  logic [7:0]  cnt_inc;
  logic [15:0] sum_new;
  logic [15:0] code_x;
  logic [15:0] code_new;
  logic [47:0] sync_win;
  logic        ack_hit;
  logic        sync_hit;
  logic        cancel_hit;
  logic [15:0] blk_num;
  pbr_req_t    req;

  assign req      = head_i.req;
  assign pop_o    = head_i.valid && (!out_valid_q || !out_stall_i);
  assign active   = (cnt_q < exp_q);
  assign cnt_inc  = cnt_q + 8'd1;
  assign sum_new  = sum_q + {8'd0, req.data};
  assign code_x   = code_q ^ {8'd0, req.data};
  assign code_new = {code_x[14:0], code_x[15]};

  // Write the incoming byte into its header slot
  always_comb begin
    hdr_w = hdr_q;
    if (cnt_q < 8'(HDR_DEPTH)) begin
      hdr_w[cnt_q[HDR_IDX_W-1:0]] = req.data;
    end
  end

  assign sync_win = {hdr_w[7], hdr_w[6], hdr_w[5], hdr_w[4], hdr_w[3], hdr_w[2]};
  assign ack_hit  = (cnt_q == ACK_COUNT) && (hdr_q[0] == CHR_A) &&
                    (hdr_q[1] == CHR_C) && (hdr_q[2] == CHR_K);
  assign sync_hit = (cnt_q == SYNC_COUNT) &&
                    ((sync_win == SYNC_ACKACK) || (sync_win == SYNC_CKACKA) ||
                     (sync_win == SYNC_KACKAC));
  assign cancel_hit = (cnt_q == ACK_COUNT) && (hdr_q[0] == CHR_S) &&
                      (hdr_q[1] == CHR_SLASH) && (hdr_q[2] == CHR_B);
  assign blk_num  = {hdr_w[6], hdr_w[5]};

  // Execute the request at the queue head
  always_comb begin
    hdr_d  = hdr_q;
    cnt_d  = cnt_q;
    exp_d  = exp_q;
    sum_d  = sum_q;
    code_d = code_q;
    rsp    = '0;
    rsp.status = ST_BUSY;
    case (req.op)
      OP_BEGIN: begin
        exp_d  = req.length;
        cnt_d  = '0;
        sum_d  = '0;
        code_d = '0;
      end
      OP_TIMEOUT: begin
        if (active) begin
          rsp.status = cancel_hit ? ST_REMOTE_CANCEL : ST_TIMEOUT;
          cnt_d      = exp_q;
        end
      end
      OP_BYTE: begin
        if (active) begin
          hdr_d = hdr_w;
          cnt_d = cnt_inc;
          if (cnt_q >= SUM_START) begin
            sum_d  = sum_new;
            code_d = code_new;
          end
          if (ack_hit) begin
            if (req.data == CHR_A) begin
              cnt_d      = '0;
              sum_d      = '0;
              code_d     = '0;
              rsp.status = ST_RESYNC;
            end else begin
              hdr_d[0]   = req.data;
              cnt_d      = 8'd1;
              rsp.status = ST_LATE_ACK;
            end
          end else if (sync_hit) begin
            cnt_d      = '0;
            sum_d      = '0;
            code_d     = '0;
            rsp.status = ST_RESYNC;
          end else begin
            // Pass payload bytes through
            if ((cnt_q >= PAYLOAD_START) && (exp_q > SHORT_LEN)) begin
              rsp.status     = ST_PAYLOAD;
              rsp.data_valid = 1'b1;
              rsp.data_byte  = req.data;
            end
            // Give the verdict on the last byte
            if (cnt_inc == exp_q) begin
              rsp.status = (({hdr_w[1], hdr_w[0]} == sum_new) &&
                            ({hdr_w[3], hdr_w[2]} == code_new)) ? ST_GOOD : ST_BAD_SUM;
              rsp.next_size    = hdr_w[4];
              rsp.block_number = blk_num;
              rsp.file_type    = (exp_q == SHORT_LEN) ? hdr_w[7] : 8'd0;
              rsp.final_block  = (blk_num[15:8] == FINAL_HI_BYTE) ||
                                 (hdr_w[4] < MIN_BLOCK_LEN);
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Hold the result while the receiver stalls
  assign out_valid_d = pop_o ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HDR_DEPTH; i++) begin
        hdr_q[i] <= '0;
      end
      cnt_q       <= '0;
      exp_q       <= MIN_BLOCK_LEN;
      sum_q       <= '0;
      code_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        hdr_q  <= hdr_d;
        cnt_q  <= cnt_d;
        exp_q  <= exp_d;
        sum_q  <= sum_d;
        code_q <= code_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/punter_block_receiver_core.sv =====
// ----------------------------------------------------------------------------
// punter_block_receiver_core
// Block receiver for a punter-style framed transfer.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i) carries begin, byte and
// timeout requests; each accepted request yields exactly one result on the
// output channel (out_valid_o / out_stall_i / out_data_o), in order.
// A begin request arms the receiver for one block; byte requests build the
// header, update the additive sum and rotate-XOR code, pass payload bytes
// through and give the verdict on the last byte.
// An accepted request is classified by the front and registered into the
// queue, then executed by the back end into the output register.
// Throughput: one request per cycle while out_stall_i is low, set by the
// single back-end state update per cycle.
// The two-entry queue between front and back takes further requests while a
// result waits; in_stall_o rises only when the queue is full, which with
// back-to-back requests happens as soon as out_stall_i holds a result.
// Reset empties the queue and output register, clears the header and checks
// and arms a seven-byte block.
// ----------------------------------------------------------------------------
module punter_block_receiver_core import pbr_pkg::*; #(
  parameter int MAX_BLOCK_LEN = 255
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pbr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pbr_out_t out_data_o
);

  pbr_req_t  front_req;
  pbr_head_t head;
  logic      queue_full;
  logic      pop;

  assign in_stall_o = queue_full;

  // Classify the incoming request
  pbr_front #(
    .MAX_BLOCK_LEN(MAX_BLOCK_LEN)
  ) u_front (
    .in_data_i(in_data_i),
    .req_o    (front_req)
  );

  // Decouple front and back
  pbr_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(in_valid_i && !queue_full),
    .req_i (front_req),
    .full_o(queue_full),
    .head_o(head),
    .pop_i (pop)
  );

  // Execute against the block state
  pbr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/core/pbr_checker.sv =====
// ----------------------------------------------------------------------------
// pbr_checker
// Port-level checks of the block receiver, bound to the top level.
// ----------------------------------------------------------------------------
module pbr_checker import pbr_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input pbr_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input pbr_out_t out_data_o
);

  logic [2:0] pending_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Track requests accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // No result without an outstanding request
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("result without a request");

  // Verdict fields only on a verdict
  a_verdict_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_GOOD) && (out_data_o.status != ST_BAD_SUM)
    |-> (out_data_o.next_size == 8'd0) && (out_data_o.block_number == 16'd0) &&
        (out_data_o.file_type == 8'd0) && !out_data_o.final_block)
    else $error("verdict fields outside a verdict");

  // Payload only with a payload or verdict status
  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.data_valid
    |-> (out_data_o.status == ST_PAYLOAD) || (out_data_o.status == ST_GOOD) ||
        (out_data_o.status == ST_BAD_SUM))
    else $error("payload byte with wrong status");

  // No data byte without payload
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.data_valid |-> out_data_o.data_byte == 8'd0)
    else $error("data byte without payload");

endmodule

bind punter_block_receiver_core pbr_checker u_pbr_checker (.*);

// ===== test/tb_punter_block_receiver_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_punter_block_receiver_core
// Self-checking bench for the block receiver. A table of directed requests
// walks reset, idle, length clamping, cancel, late-ACK and lost-sync cases.
// Random traffic follows: mostly sealed blocks (correct sum and rotate-XOR
// code), mixed with corrupted, truncated, cancelled, ACK-prefixed and
// lost-sync blocks and loose noise. Every accepted request is run through a
// behavioural copy of the receiver, and each result must match in order.
// ----------------------------------------------------------------------------
module tb_punter_block_receiver_core;
  import pbr_pkg::*;

  localparam int unsigned CLK_HALF        = 10;
  localparam int unsigned RESET_CYCLES    = 8;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned TARGET_ITEMS    = 1550;
  localparam int unsigned MID_DRAIN_ITEMS = 800;
  localparam int unsigned CALM_ITEMS      = 1350;
  localparam int unsigned HOLD_AFTER      = 300;
  localparam int unsigned HOLD_CYCLES     = 48;
  localparam int unsigned TAIL_CYCLES     = 8;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam logic [1:0]  KIND_UNUSED     = 2'd3;
  localparam logic [15:0] FINAL_BLOCK_NUM = 16'hff00;

  typedef enum int {
    FR_PLAIN,
    FR_RESYNC,
    FR_LATE_ACK,
    FR_LOST_SYNC,
    FR_TRUNCATE
  } frame_mode_e;

  typedef struct packed {
    pbr_in_t     req;
    logic        fixed;
    pbr_status_e fixed_st;
  } probe_row_t;

  // Directed requests; rows with fixed set carry a hand-written status,
  // all other result fields being zero
  localparam int unsigned PROBE_COUNT = 24;
  localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
    '{'{KIND_UNUSED,  8'hff, 8'hff}, 1'b1, ST_BUSY},
    '{'{KIND_TIMEOUT, 8'h00, 8'h00}, 1'b1, ST_TIMEOUT},
    '{'{KIND_BYTE,    8'h00, 8'h00}, 1'b1, ST_BUSY},
    '{'{KIND_BEGIN,   8'h00, 8'hff}, 1'b1, ST_BUSY},
    '{'{KIND_BYTE,    8'hff, "S"},   1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, "/"},   1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'hff, "B"},   1'b0, ST_BUSY},
    '{'{KIND_TIMEOUT, 8'hff, 8'hff}, 1'b1, ST_REMOTE_CANCEL},
    '{'{KIND_BEGIN,   8'hff, 8'h00}, 1'b1, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, "A"},   1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, "C"},   1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, "K"},   1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, "A"},   1'b1, ST_RESYNC},
    '{'{KIND_BYTE,    8'h00, "A"},   1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, "C"},   1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, "K"},   1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, 8'h00}, 1'b1, ST_LATE_ACK},
    '{'{KIND_BYTE,    8'h00, 8'hff}, 1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, "A"},   1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, "C"},   1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, "K"},   1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, "A"},   1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, "C"},   1'b0, ST_BUSY},
    '{'{KIND_BYTE,    8'h00, "K"},   1'b1, ST_RESYNC}
  };

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  pbr_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  pbr_out_t out_data_o;

  // Behavioural receiver state
  logic [7:0]  hdr [8];
  logic [7:0]  rx_count;
  logic [7:0]  blk_len;
  logic [15:0] add_sum;
  logic [15:0] rot_code;

  pbr_out_t    answers_due [$];
  pbr_out_t    seen_res;
  pbr_out_t    due_res;
  int unsigned live_items = 0;
  int unsigned bad_count  = 0;
  int unsigned cycle_ctr  = 0;
  bit          calm_tail  = 1'b0;

  punter_block_receiver_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_ctr <= cycle_ctr + 1;
    if (cycle_ctr == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Work out the receiver's answer to one request and advance its state
  function automatic pbr_out_t receiver_answer(input pbr_in_t req);
    pbr_out_t    res;
    logic [7:0]  idx;
    logic [7:0]  b;
    logic [15:0] blk;
    logic [47:0] win;
    logic        good;
    res = '0;
    if (req.kind == KIND_BEGIN) begin
      // clamp the length; the upper bound is the full byte range
      blk_len  = (req.block_length < MIN_BLOCK_LEN) ? MIN_BLOCK_LEN : req.block_length;
      rx_count = '0;
      add_sum  = '0;
      rot_code = '0;
      return res;
    end
    if (req.kind == KIND_UNUSED || rx_count >= blk_len) return res;
    if (req.kind == KIND_TIMEOUT) begin
      res.status = (rx_count == 8'd3 && {hdr[0], hdr[1], hdr[2]} == "S/B") ?
                   ST_REMOTE_CANCEL : ST_TIMEOUT;
      rx_count = blk_len;
      return res;
    end
    idx = rx_count;
    b   = req.rx_byte;
    if (idx < 8'd8) hdr[idx[2:0]] = b;
    if (idx >= 8'd4) begin
      add_sum  = add_sum + {8'h00, b};
      rot_code = rot_code ^ {8'h00, b};
      rot_code = {rot_code[14:0], rot_code[15]};
    end
    rx_count = idx + 8'd1;
    // late ACK at the head of the block
    if (rx_count == 8'd4 && {hdr[0], hdr[1], hdr[2]} == "ACK") begin
      if (hdr[3] == "A") begin
        rx_count   = '0;
        add_sum    = '0;
        rot_code   = '0;
        res.status = ST_RESYNC;
      end else begin
        hdr[0]     = hdr[3];
        rx_count   = 8'd1;
        res.status = ST_LATE_ACK;
      end
      return res;
    end
    // lost sync wins over any verdict
    if (rx_count == 8'd8) begin
      win = {hdr[2], hdr[3], hdr[4], hdr[5], hdr[6], hdr[7]};
      if (win == "ACKACK" || win == "CKACKA" || win == "KACKAC") begin
        rx_count   = '0;
        add_sum    = '0;
        rot_code   = '0;
        res.status = ST_RESYNC;
        return res;
      end
    end
    if (idx >= 8'd7 && blk_len > 8'd8) begin
      res.status     = ST_PAYLOAD;
      res.data_valid = 1'b1;
      res.data_byte  = b;
    end
    if (rx_count == blk_len) begin
      blk  = {hdr[6], hdr[5]};
      good = ({hdr[1], hdr[0]} == add_sum) && ({hdr[3], hdr[2]} == rot_code);
      res.status       = good ? ST_GOOD : ST_BAD_SUM;
      res.next_size    = hdr[4];
      res.block_number = blk;
      res.file_type    = (blk_len == SHORT_LEN) ? hdr[7] : 8'h00;
      res.final_block  = (blk >= FINAL_BLOCK_NUM) || (hdr[4] < MIN_BLOCK_LEN);
    end
    return res;
  endfunction

  // Offer one request, hold it until taken, then log what must come back
  task automatic drive_request(input pbr_in_t req, input bit fixed,
                               input pbr_status_e fixed_st);
    pbr_out_t want;
    if (!calm_tail && (cycle_ctr % 512) >= 128 && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (req.kind == KIND_BEGIN || (req.kind != KIND_UNUSED && rx_count < blk_len))
      live_items++;
    want = receiver_answer(req);
    if (fixed) begin
      want        = '0;
      want.status = fixed_st;
    end
    answers_due.push_back(want);
  endtask

  task automatic send_byte(input logic [7:0] b);
    pbr_in_t req;
    req.kind         = KIND_BYTE;
    req.block_length = 8'($urandom_range(0, 255));
    req.rx_byte      = b;
    drive_request(req, 1'b0, ST_BUSY);
  endtask

  task automatic send_begin(input logic [7:0] len);
    pbr_in_t req;
    req.kind         = KIND_BEGIN;
    req.block_length = len;
    req.rx_byte      = 8'($urandom_range(0, 255));
    drive_request(req, 1'b0, ST_BUSY);
  endtask

  task automatic send_timeout();
    pbr_in_t req;
    req.kind         = KIND_TIMEOUT;
    req.block_length = 8'($urandom_range(0, 255));
    req.rx_byte      = 8'($urandom_range(0, 255));
    drive_request(req, 1'b0, ST_BUSY);
  endtask

  // Build a sealed block, optionally damage it, and send it behind a prefix
  task automatic send_framed(input frame_mode_e mode);
    logic [7:0]  frame [$];
    logic [7:0]  len_field;
    logic [7:0]  n;
    logic [15:0] sum;
    logic [15:0] code;
    logic [47:0] pat;
    int          i;
    int          sel;
    int          cut;
    int          hit;
    sel = $urandom_range(0, 19);
    if (sel < 13)      len_field = 8'($urandom_range(9, 16));
    else if (sel < 16) len_field = SHORT_LEN;
    else if (sel < 18) len_field = 8'($urandom_range(0, 7));
    else               len_field = 8'($urandom_range(17, 255));
    if (mode == FR_LOST_SYNC && len_field < SHORT_LEN) len_field = SHORT_LEN;
    n = (len_field < MIN_BLOCK_LEN) ? MIN_BLOCK_LEN : len_field;
    for (i = 0; i < n; i++) frame.push_back(8'($urandom_range(0, 255)));
    frame[4] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 6)) :
                                             8'($urandom_range(7, 255));
    if ($urandom_range(0, 4) == 0) frame[6] = 8'hff;
    sum  = '0;
    code = '0;
    for (i = 4; i < n; i++) begin
      sum  = sum + {8'h00, frame[i]};
      code = code ^ {8'h00, frame[i]};
      code = {code[14:0], code[15]};
    end
    frame[0] = sum[7:0];
    frame[1] = sum[15:8];
    frame[2] = code[7:0];
    frame[3] = code[15:8];
    // flip one bit now and then
    if ($urandom_range(0, 6) == 0) begin
      hit        = $urandom_range(0, n - 1);
      frame[hit] = frame[hit] ^ (8'h01 << $urandom_range(0, 7));
    end
    send_begin(len_field);
    case (mode)
      FR_RESYNC: begin
        send_byte("A");
        send_byte("C");
        send_byte("K");
        send_byte("A");
      end
      FR_LATE_ACK: begin
        send_byte("A");
        send_byte("C");
        send_byte("K");
      end
      FR_LOST_SYNC: begin
        case ($urandom_range(0, 2))
          0:       pat = "ACKACK";
          1:       pat = "CKACKA";
          default: pat = "KACKAC";
        endcase
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        for (i = 5; i >= 0; i--) send_byte(pat[i*8 +: 8]);
      end
      default: ;
    endcase
    cut = (mode == FR_TRUNCATE) ? $urandom_range(0, n - 1) : n;
    for (i = 0; i < cut; i++) send_byte(frame[i]);
    if (mode == FR_TRUNCATE) send_timeout();
  endtask

  // Compare each result with the oldest pending answer
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      seen_res = out_data_o;
      if (answers_due.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_REPORTS)
          $display("unexpected result: status=%0d byte=%02h", seen_res.status,
                   seen_res.data_byte);
      end else begin
        due_res = answers_due.pop_front();
        if (seen_res.status       !== due_res.status       ||
            seen_res.data_valid   !== due_res.data_valid   ||
            seen_res.data_byte    !== due_res.data_byte    ||
            seen_res.next_size    !== due_res.next_size    ||
            seen_res.block_number !== due_res.block_number ||
            seen_res.file_type    !== due_res.file_type    ||
            seen_res.final_block  !== due_res.final_block) begin
          bad_count++;
          if (bad_count <= MAX_REPORTS)
            $display("mismatch: got st=%0d dv=%0b db=%02h ns=%02h bn=%04h ft=%02h fb=%0b",
                     seen_res.status, seen_res.data_valid, seen_res.data_byte,
                     seen_res.next_size, seen_res.block_number, seen_res.file_type,
                     seen_res.final_block, "\n          exp st=%0d dv=%0b db=%02h",
                     due_res.status, due_res.data_valid, due_res.data_byte,
                     " ns=%02h bn=%04h ft=%02h fb=%0b", due_res.next_size,
                     due_res.block_number, due_res.file_type, due_res.final_block);
        end
      end
    end
  end

  // Stall the result side in short bursts, plus one long hold-off
  initial begin : result_backpressure
    int unsigned taken;
    bit          held_off;
    taken    = 0;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) taken++;
      if (!held_off && taken >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm_tail && ((cycle_ctr + 256) % 512) >= 128 &&
                   $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Reset, directed table, random traffic, drain
  initial begin : request_source
    pbr_in_t noise;
    int      pick;
    int      k;
    bit      mid_drained;
    mid_drained = 1'b0;
    for (k = 0; k < 8; k++) hdr[k] = 8'h00;
    rx_count = '0;
    blk_len  = MIN_BLOCK_LEN;
    add_sum  = '0;
    rot_code = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < PROBE_COUNT; k++)
      drive_request(PROBE_ROWS[k].req, PROBE_ROWS[k].fixed, PROBE_ROWS[k].fixed_st);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (answers_due.size() != 0);

    while (live_items < TARGET_ITEMS) begin
      // pause the source once until everything has come back
      if (!mid_drained && live_items >= MID_DRAIN_ITEMS) begin
        mid_drained = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (answers_due.size() != 0);
      end
      if (live_items >= CALM_ITEMS) calm_tail = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55)      send_framed(FR_PLAIN);
      else if (pick < 63) send_framed(FR_RESYNC);
      else if (pick < 71) send_framed(FR_LATE_ACK);
      else if (pick < 78) send_framed(FR_LOST_SYNC);
      else if (pick < 86) send_framed(FR_TRUNCATE);
      else if (pick < 92) begin
        // cancel after S/B, sometimes with the last character spoiled
        send_begin(8'($urandom_range(0, 255)));
        send_byte("S");
        send_byte("/");
        send_byte(($urandom_range(0, 9) < 7) ? "B" : 8'($urandom_range(0, 255)));
        send_timeout();
      end else begin
        for (k = $urandom_range(1, 5); k > 0; k--) begin
          noise.kind         = 2'($urandom_range(0, 3));
          noise.block_length = 8'($urandom_range(0, 255));
          noise.rx_byte      = 8'($urandom_range(0, 255));
          drive_request(noise, 1'b0, ST_BUSY);
        end
      end
    end

    calm_tail = 1'b1;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (answers_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (bad_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
